### sv/ska_pkg.sv
package ska_pkg;

  // Default slot count of the allocator
  localparam int unsigned SlotCountDef = 255;

  // Slots held by one cell of the chain
  localparam int unsigned GroupW  = 16;
  localparam int unsigned GroupBW = 4;

  // Slot index width inside the block, wide enough for the largest slot count (4096)
  localparam int unsigned IdxW = 13;

  // Item modes
  localparam logic [2:0] MODE_TAKE   = 3'd0;
  localparam logic [2:0] MODE_GIVE   = 3'd1;
  localparam logic [2:0] MODE_ACT    = 3'd2;
  localparam logic [2:0] MODE_CLR    = 3'd3;
  localparam logic [2:0] MODE_QUERY  = 3'd4;

  // Result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_NOT_USED = 2'd2;

  // Update broadcast to every cell
  typedef struct packed {
    logic            set;
    logic            clr;
    logic [IdxW-1:0] idx;
  } cmd_t;

  // Lowest free slot at or above a cell, handed down the chain
  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] idx;
  } free_t;

endpackage

### sv/ska_cell.sv
module ska_cell #(
  parameter int unsigned SLOT_COUNT = ska_pkg::SlotCountDef,
  parameter int unsigned CELL_ID    = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ska_pkg::cmd_t               cmd_i,
  input  logic [ska_pkg::IdxW-1:0]    rd_idx_i,
  input  ska_pkg::free_t              free_i,
  output ska_pkg::free_t              free_o,
  output logic                        rd_o
);

  localparam int unsigned GW   = ska_pkg::GroupW;
  localparam int unsigned GBW  = ska_pkg::GroupBW;
  localparam int unsigned IW   = ska_pkg::IdxW;
  localparam int unsigned BASE = CELL_ID * GW;

  logic [GW-1:0]  used_q, used_d;
  logic [GW-1:0]  slot_ok;
  logic           wr_hit, rd_hit;
  logic [GBW-1:0] loc_pos;
  logic           loc_found;
  ska_pkg::free_t free_q, free_d;
  logic           rd_q;

  // Slots past the end of the range never exist
  always_comb begin
    for (int j = 0; j < GW; j++) begin
      slot_ok[j] = ((BASE + j) < SLOT_COUNT);
    end
  end

  assign wr_hit = (cmd_i.idx[IW-1:GBW] == (IW-GBW)'(CELL_ID));
  assign rd_hit = (rd_idx_i[IW-1:GBW] == (IW-GBW)'(CELL_ID));

  always_comb begin
    used_d = used_q;
    if (wr_hit && slot_ok[cmd_i.idx[GBW-1:0]]) begin
      if (cmd_i.set) begin
        used_d[cmd_i.idx[GBW-1:0]] = 1'b1;
      end else if (cmd_i.clr) begin
        used_d[cmd_i.idx[GBW-1:0]] = 1'b0;
      end
    end
  end

  // Lowest free slot within this cell
  always_comb begin
    loc_found = 1'b0;
    loc_pos   = '0;
    for (int j = GW - 1; j >= 0; j--) begin
      if (slot_ok[j] && !used_q[j]) begin
        loc_found = 1'b1;
        loc_pos   = GBW'(j);
      end
    end
  end

  always_comb begin
    if (loc_found) begin
      free_d.found = 1'b1;
      free_d.idx   = {(IW-GBW)'(CELL_ID), loc_pos};
    end else begin
      free_d = free_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      free_q <= '0;
    end else begin
      used_q <= used_d;
      free_q <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= rd_hit && slot_ok[rd_idx_i[GBW-1:0]] && used_q[rd_idx_i[GBW-1:0]];
  end

  assign free_o = free_q;
  assign rd_o   = rd_q;

endmodule

### sv/slot_key_allocator.sv
// Slot allocator: one used bit per slot, a count of slots in use and one active-slot
// mark. Every item gives one result. A take (mode 0) hands out the lowest free slot or
// reports full. A give back (mode 1) frees an in-use slot and drops the active mark if it
// names that slot. Activate (mode 2) marks an in-use slot active. Clear (mode 3) drops the
// mark. Query (mode 4) reports one slot. Modes 5 to 7 change nothing. The used bits sit in
// a chain of cells, GroupW slots each. Every cell registers the lowest free slot at or
// above itself, taking the registered answer of the cell above it. Cell 0 therefore holds
// the global lowest free slot once the chain has settled. A settle counter, loaded with
// CELLS after reset and after every take or give back, counts down to that point; CELLS
// is 16 at 255 slots. The controller steps idle, read, execute: an item accepted in idle
// reads the named slot in the cells in the next cycle and executes in the one after,
// where its result is registered as it returns to idle; no new item is accepted before
// then. A take that will not report full and comes soon after a change waits in execute
// until the chain has settled. in_stall_o is high from accept until the result is
// registered; a result register that is full and stalled holds execute as well. A
// finished result waits in the output register while the next item is accepted.
module slot_key_allocator #(
  parameter int unsigned SLOT_COUNT = ska_pkg::SlotCountDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] mode_i,
  input  logic [7:0] slot_number_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [7:0] granted_slot_o,
  output logic       queried_in_use_o,
  output logic       has_active_o,
  output logic [7:0] active_slot_out_o,
  output logic       all_taken_o,
  output logic [7:0] slots_in_use_o
);

  localparam int unsigned GW    = ska_pkg::GroupW;
  localparam int unsigned IW    = ska_pkg::IdxW;
  localparam int unsigned CELLS = (SLOT_COUNT + GW - 1) / GW;
  localparam int unsigned CNTW  = $clog2(SLOT_COUNT + 1);
  localparam int unsigned STLW  = $clog2(CELLS + 1);

  // Controller states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [2:0]      mode_q;
  logic [7:0]      slot_q;
  logic            in_range_q;

  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            act_flag_q, act_flag_d;
  logic [7:0]      act_idx_q, act_idx_d;
  logic [STLW-1:0] settle_q, settle_d;

  logic            out_valid_q;
  logic [1:0]      status_q;
  logic [7:0]      granted_q;
  logic            queried_q;
  logic            has_act_q;
  logic [7:0]      act_out_q;
  logic            all_taken_q;
  logic [7:0]      in_use_q;

  ska_pkg::free_t  chain [CELLS+1];
  logic [CELLS-1:0] rd_vec;
  ska_pkg::cmd_t   cmd;

  logic            accept;
  logic            out_free;
  logic            full;
  logic            pre_used;
  logic            can_exec;
  logic            commit;
  logic            take_ok, give_ok;
  logic [1:0]      status_d;
  logic [IW-1:0]   grant_idx;
  logic            queried_d;

  // ---------------------------------------------------------------------------------
  // Cell chain: the last cell sees no free slot above it
  // ---------------------------------------------------------------------------------
  assign chain[CELLS] = '0;

  for (genvar c = 0; c < CELLS; c++) begin : g_cell
    ska_cell #(
      .SLOT_COUNT(SLOT_COUNT),
      .CELL_ID   (c)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .rd_idx_i(IW'(slot_q)),
      .free_i  (chain[c+1]),
      .free_o  (chain[c]),
      .rd_o    (rd_vec[c])
    );
  end

  // ---------------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------------
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------------------------
  // Execute
  // ---------------------------------------------------------------------------------
  assign full      = (cnt_q == CNTW'(SLOT_COUNT));
  // out-of-range slots never read as used
  assign pre_used  = (|rd_vec) && in_range_q;
  assign grant_idx = chain[0].idx;

  // a take needs a settled chain unless it will report full
  assign can_exec = !((mode_q == ska_pkg::MODE_TAKE) && !full && (settle_q != '0));
  assign commit   = (state_q == S_EXEC) && can_exec && out_free;

  always_comb begin
    status_d   = ska_pkg::STATUS_OK;
    take_ok    = 1'b0;
    give_ok    = 1'b0;
    cnt_d      = cnt_q;
    act_flag_d = act_flag_q;
    act_idx_d  = act_idx_q;
    unique case (mode_q)
      ska_pkg::MODE_TAKE: begin
        if (full) begin
          status_d = ska_pkg::STATUS_FULL;
        end else begin
          take_ok = 1'b1;
          cnt_d   = cnt_q + CNTW'(1);
        end
      end
      ska_pkg::MODE_GIVE: begin
        if (pre_used) begin
          give_ok = 1'b1;
          cnt_d   = cnt_q - CNTW'(1);
          if (act_flag_q && (act_idx_q == slot_q)) begin
            act_flag_d = 1'b0;
          end
        end else begin
          status_d = ska_pkg::STATUS_NOT_USED;
        end
      end
      ska_pkg::MODE_ACT: begin
        if (pre_used) begin
          act_flag_d = 1'b1;
          act_idx_d  = slot_q;
        end else begin
          status_d = ska_pkg::STATUS_NOT_USED;
        end
      end
      ska_pkg::MODE_CLR: begin
        act_flag_d = 1'b0;
      end
      ska_pkg::MODE_QUERY: begin
        if (!in_range_q) begin
          status_d = ska_pkg::STATUS_NOT_USED;
        end
      end
      default: begin
      end
    endcase
  end

  // used bit of the named slot after this item
  assign queried_d = (pre_used && (mode_q != ska_pkg::MODE_GIVE))
                  || (take_ok && (grant_idx == IW'(slot_q)));

  always_comb begin
    cmd.set = commit && take_ok;
    cmd.clr = commit && give_ok;
    cmd.idx = take_ok ? grant_idx : IW'(slot_q);
  end

  always_comb begin
    if (commit && (take_ok || give_ok)) begin
      settle_d = STLW'(CELLS);
    end else if (settle_q != '0) begin
      settle_d = settle_q - STLW'(1);
    end else begin
      settle_d = settle_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_READ;
      S_READ: state_d = S_EXEC;
      S_EXEC: if (commit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      act_flag_q  <= 1'b0;
      act_idx_q   <= '0;
      settle_q    <= STLW'(CELLS);
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      settle_q <= settle_d;
      if (commit) begin
        cnt_q      <= cnt_d;
        act_flag_q <= act_flag_d;
        act_idx_q  <= act_idx_d;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q     <= mode_i;
      slot_q     <= slot_number_i;
      in_range_q <= (IW'(slot_number_i) < IW'(SLOT_COUNT));
    end
    if (commit) begin
      status_q    <= status_d;
      granted_q   <= take_ok ? 8'(grant_idx) : 8'd0;
      queried_q   <= queried_d;
      has_act_q   <= act_flag_d;
      act_out_q   <= act_flag_d ? act_idx_d : 8'd0;
      all_taken_q <= (cnt_d == CNTW'(SLOT_COUNT));
      in_use_q    <= 8'(cnt_d);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign granted_slot_o    = granted_q;
  assign queried_in_use_o  = queried_q;
  assign has_active_o      = has_act_q;
  assign active_slot_out_o = act_out_q;
  assign all_taken_o       = all_taken_q;
  assign slots_in_use_o    = in_use_q;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

// Testbench for slot_key_allocator.
// A shadow copy of the allocator state predicts one result per accepted item.
// The checker compares every accepted result against the oldest prediction.
module tb;

  localparam int unsigned NumSlots    = ska_pkg::SlotCountDef;
  localparam int unsigned RandItems   = 1400;
  localparam int unsigned PhaseItems  = 300;
  // Covers a take waiting on the chain plus the output stage.
  localparam int unsigned SettleWait  = 40;
  localparam int unsigned CycleLimit  = 1000000;

  // Modes 5 to 7 carry no operation; the block must leave its state alone.
  localparam logic [2:0] MODE_NOP_LO  = 3'd5;
  localparam logic [2:0] MODE_NOP_MID = 3'd6;
  localparam logic [2:0] MODE_NOP_HI  = 3'd7;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] granted;
    logic       in_use;
    logic       has_act;
    logic [7:0] act_slot;
    logic       full;
    logic [7:0] count;
  } alloc_res_t;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Item side; every input holds a known value from time zero
  logic       in_valid_i    = 1'b0;
  logic       in_stall_o;
  logic [2:0] mode_i        = ska_pkg::MODE_TAKE;
  logic [7:0] slot_number_i = 8'd0;

  // Result side
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [1:0] status_o;
  logic [7:0] granted_slot_o;
  logic       queried_in_use_o;
  logic       has_active_o;
  logic [7:0] active_slot_out_o;
  logic       all_taken_o;
  logic [7:0] slots_in_use_o;

  // Shadow allocator state, advanced once per accepted item
  logic [NumSlots-1:0] shadow_used;
  int unsigned         shadow_count;
  logic                shadow_act_flag;
  logic [7:0]          shadow_act_slot;

  // Predictions waiting for their result, oldest first
  alloc_res_t  pending_res_q[$];

  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned cycles = 0;

  // Idle knobs: percent chance of a sender gap before an item, and of a
  // receiver stall stretch when the previous stretch runs out.
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_left = 0;
  logic        stall_now  = 1'b0;

  always #4 clk_i = ~clk_i;

  slot_key_allocator #(
    .SLOT_COUNT(NumSlots)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .slot_number_i    (slot_number_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .granted_slot_o   (granted_slot_o),
    .queried_in_use_o (queried_in_use_o),
    .has_active_o     (has_active_o),
    .active_slot_out_o(active_slot_out_o),
    .all_taken_o      (all_taken_o),
    .slots_in_use_o   (slots_in_use_o)
  );

  // Idle length: mostly short, now and then a long one.
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Advance the shadow state by one item and return the result it must give.
  function automatic alloc_res_t alloc_predict(logic [2:0] mode, logic [7:0] slot);
    alloc_res_t res;
    logic       in_range;
    logic       busy;
    logic       found;
    res        = '0;
    res.status = ska_pkg::STATUS_OK;
    in_range   = (int'(slot) < NumSlots);
    busy       = in_range ? shadow_used[slot] : 1'b0;
    found      = 1'b0;
    case (mode)
      ska_pkg::MODE_TAKE: begin
        // lowest free slot wins; nothing moves when all are taken
        res.status = ska_pkg::STATUS_FULL;
        for (int i = 0; i < NumSlots; i++) begin
          if (!found && !shadow_used[i]) begin
            found          = 1'b1;
            shadow_used[i] = 1'b1;
            shadow_count++;
            res.granted    = 8'(i);
            res.status     = ska_pkg::STATUS_OK;
          end
        end
      end
      ska_pkg::MODE_GIVE: begin
        if (!busy) begin
          res.status = ska_pkg::STATUS_NOT_USED;
        end else begin
          // freeing the marked slot drops the mark too
          if (shadow_act_flag && shadow_act_slot == slot) shadow_act_flag = 1'b0;
          shadow_used[slot] = 1'b0;
          shadow_count--;
        end
      end
      ska_pkg::MODE_ACT: begin
        if (!busy) begin
          res.status = ska_pkg::STATUS_NOT_USED;
        end else begin
          shadow_act_slot = slot;
          shadow_act_flag = 1'b1;
        end
      end
      ska_pkg::MODE_CLR: begin
        shadow_act_flag = 1'b0;
      end
      ska_pkg::MODE_QUERY: begin
        if (!in_range) res.status = ska_pkg::STATUS_NOT_USED;
      end
      default: begin
      end
    endcase
    // state-after-step fields, reported for every mode
    res.in_use   = in_range ? shadow_used[slot] : 1'b0;
    res.has_act  = shadow_act_flag;
    res.act_slot = shadow_act_flag ? shadow_act_slot : 8'd0;
    res.full     = (shadow_count == NumSlots);
    res.count    = 8'(shadow_count);
    return res;
  endfunction

  // Random slot that is currently in use, or any slot when none is.
  function automatic logic [7:0] pick_used();
    int unsigned start;
    start = $urandom_range(0, NumSlots - 1);
    for (int k = 0; k < NumSlots; k++) begin
      if (shadow_used[(start + k) % NumSlots]) return 8'((start + k) % NumSlots);
    end
    return 8'(start);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("[%0t] result %0d: %s got %0d want %0d", $realtime, results_seen, what, got,
             want);
  endtask

  // Offer one item, after an optional gap, and hold it until accepted.
  // Called at a rising edge; returns at the edge that accepted the item.
  task automatic send_item(input logic [2:0] mode, input logic [7:0] slot);
    int unsigned gap;
    gap = ($urandom_range(0, 99) < gap_pct) ? idle_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= mode;
    slot_number_i <= slot;
    do @(posedge clk_i); while (in_stall_o);
    pending_res_q.push_back(alloc_predict(mode, slot));
  endtask

  // Sender pause: nothing offered until every prediction has been matched,
  // then enough quiet cycles for a trailing take to finish.
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    while (pending_res_q.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  // Receiver: alternating stretches of stall and no stall.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_now  = ($urandom_range(0, 99) < stall_pct);
      stall_left = stall_now ? idle_len() : $urandom_range(1, 12);
    end
    stall_left--;
    out_stall_i <= stall_now;
  end

  // Checker: every accepted result against the oldest prediction.
  always @(posedge clk_i) begin : check_results
    alloc_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_res_q.size() == 0) begin
        report_mismatch("unexpected result, pending", 0, 0);
      end else begin
        want = pending_res_q.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", status_o, want.status);
        if (granted_slot_o !== want.granted)
          report_mismatch("granted_slot", granted_slot_o, want.granted);
        if (queried_in_use_o !== want.in_use)
          report_mismatch("queried_in_use", queried_in_use_o, want.in_use);
        if (has_active_o !== want.has_act)
          report_mismatch("has_active", has_active_o, want.has_act);
        if (active_slot_out_o !== want.act_slot)
          report_mismatch("active_slot_out", active_slot_out_o, want.act_slot);
        if (all_taken_o !== want.full)
          report_mismatch("all_taken", all_taken_o, want.full);
        if (slots_in_use_o !== want.count)
          report_mismatch("slots_in_use", slots_in_use_o, want.count);
      end
      results_seen++;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Edge cases from an empty allocator: out-of-range and free slots, empty
  // clear, unused modes, and the active mark following give backs.
  task automatic test_edge_cases();
    gap_pct   = 30;
    stall_pct = 30;
    send_item(ska_pkg::MODE_QUERY, 8'd0);      // free slot in range
    send_item(ska_pkg::MODE_QUERY, 8'd255);    // beyond the last slot
    send_item(ska_pkg::MODE_GIVE,  8'd0);      // give back of a free slot
    send_item(ska_pkg::MODE_GIVE,  8'd255);
    send_item(ska_pkg::MODE_ACT,   8'd0);      // activate a free slot
    send_item(ska_pkg::MODE_ACT,   8'd255);
    send_item(ska_pkg::MODE_CLR,   8'd0);      // clear with nothing marked
    send_item(MODE_NOP_LO, 8'd255);
    send_item(MODE_NOP_MID, 8'hAA);
    send_item(MODE_NOP_HI, 8'h55);
    send_item(ska_pkg::MODE_TAKE,  8'd255);    // slot field is ignored by take
    send_item(ska_pkg::MODE_TAKE,  8'd0);
    send_item(ska_pkg::MODE_TAKE,  8'd0);
    send_item(ska_pkg::MODE_ACT,   8'd1);
    send_item(ska_pkg::MODE_QUERY, 8'd1);
    send_item(ska_pkg::MODE_GIVE,  8'd2);      // mark stays on slot 1
    send_item(ska_pkg::MODE_GIVE,  8'd1);      // mark goes with its slot
    send_item(ska_pkg::MODE_TAKE,  8'd0);      // reuses slot 1
    send_item(ska_pkg::MODE_ACT,   8'd0);
    send_item(ska_pkg::MODE_CLR,   8'd7);
    send_item(ska_pkg::MODE_ACT,   8'd0);
    send_item(ska_pkg::MODE_ACT,   8'd1);      // mark moves to slot 1
    send_item(ska_pkg::MODE_GIVE,  8'd0);      // unmarked slot freed
    send_item(MODE_NOP_HI, 8'd1);
  endtask

  // Take until every slot is used, then poke the full allocator.
  task automatic test_fill_to_full();
    gap_pct   = 0;
    stall_pct = 0;
    while (shadow_count < NumSlots) begin
      send_item(ska_pkg::MODE_TAKE, 8'($urandom_range(0, 255)));
    end
    gap_pct   = 25;
    stall_pct = 25;
    send_item(ska_pkg::MODE_TAKE,  8'd0);
    send_item(ska_pkg::MODE_TAKE,  8'd255);
    send_item(ska_pkg::MODE_ACT,   8'(NumSlots - 1));
    send_item(ska_pkg::MODE_QUERY, 8'(NumSlots - 1));
    send_item(ska_pkg::MODE_GIVE,  8'(NumSlots - 1));
    send_item(ska_pkg::MODE_GIVE,  8'd255);
    send_item(ska_pkg::MODE_TAKE,  8'd0);      // highest slot comes back
    send_item(ska_pkg::MODE_GIVE,  8'd100);
    send_item(ska_pkg::MODE_TAKE,  8'd0);      // then slot 100
    send_item(ska_pkg::MODE_TAKE,  8'd0);
  endtask

  // Random mix in phases that fill, churn or drain the allocator, each with
  // its own idle pressure. Each phase begins after a full sender pause.
  task automatic test_random_mix();
    int unsigned real_items;
    int unsigned phase_left;
    int unsigned take_w;
    int unsigned give_w;
    int unsigned pick;
    logic [2:0]  mode;
    logic [7:0]  slot;
    real_items = 0;
    phase_left = 0;
    take_w     = 35;
    give_w     = 35;
    while (real_items < RandItems) begin
      if (phase_left == 0) begin
        hold_until_drained();
        phase_left = PhaseItems;
        case ($urandom_range(0, 2))
          0:       begin take_w = 62; give_w = 8;  end
          1:       begin take_w = 35; give_w = 35; end
          default: begin take_w = 10; give_w = 60; end
        endcase
        case ($urandom_range(0, 2))
          0:       begin gap_pct = 0;  stall_pct = 0;  end
          1:       begin gap_pct = 20; stall_pct = 25; end
          default: begin gap_pct = 50; stall_pct = 50; end
        endcase
      end
      pick = $urandom_range(0, 99);
      slot = 8'($urandom_range(0, 255));
      if (pick < take_w) begin
        mode = ska_pkg::MODE_TAKE;
      end else if (pick < take_w + give_w) begin
        mode = ska_pkg::MODE_GIVE;
        if ($urandom_range(0, 4) != 0) slot = pick_used();
      end else if (pick < 78) begin
        mode = ska_pkg::MODE_ACT;
        if ($urandom_range(0, 4) != 0) slot = pick_used();
      end else if (pick < 84) begin
        mode = ska_pkg::MODE_CLR;
      end else if (pick < 94) begin
        mode = ska_pkg::MODE_QUERY;
      end else begin
        mode = 3'($urandom_range(MODE_NOP_HI, MODE_NOP_LO));
      end
      send_item(mode, slot);
      if (mode <= ska_pkg::MODE_QUERY) real_items++;
      phase_left--;
    end
  endtask

  // Pause, then free every slot in random order and start over from empty.
  task automatic test_drain_all();
    hold_until_drained();
    gap_pct   = 20;
    stall_pct = 30;
    if (shadow_count != 0) send_item(ska_pkg::MODE_ACT, pick_used());
    while (shadow_count != 0) send_item(ska_pkg::MODE_GIVE, pick_used());
    send_item(ska_pkg::MODE_QUERY, 8'd0);
    send_item(ska_pkg::MODE_TAKE,  8'd0);
    send_item(ska_pkg::MODE_GIVE,  8'd0);
  endtask

  initial begin
    shadow_used     = '0;
    shadow_count    = 0;
    shadow_act_flag = 1'b0;
    shadow_act_slot = 8'd0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edge_cases();
    test_fill_to_full();
    test_random_mix();
    test_drain_all();

    hold_until_drained();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
